### hw/rtl/point_charge_field_accumulator_macros.svh
// Assertion macros for the point charge field accumulator checker.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef POINT_CHARGE_FIELD_ACCUMULATOR_MACROS_SVH
`define POINT_CHARGE_FIELD_ACCUMULATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PCFA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PCFA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/pcfa_pkg.sv
// Shared types and constants of the point charge field accumulator.
// No dependencies.
package pcfa_pkg;

  localparam int unsigned ArithW     = 128;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned CfgIndexW  = 2;

  typedef enum logic [CfgIndexW-1:0] {
    CfgTpX = 2'd0,
    CfgTpY = 2'd1,
    CfgTpZ = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OpMul  = 3'b001,
    OpDiv  = 3'b010,
    OpSqrt = 3'b100
  } arith_op_e;

  // One classified charge: separation vector, 9*|q| and flags.
  typedef struct packed {
    logic [2:0][32:0] r;
    logic [34:0]      kq;
    logic             qneg;
    logic             singular;
    logic             skip;
    logic             last;
  } item_t;

  typedef struct packed {
    logic [47:0]      mag;
    logic [2:0][15:0] dir;
    logic             singular;
    logic             zero;
  } result_t;

  typedef struct packed {
    logic              start;
    arith_op_e         op;
    logic [ArithW-1:0] a;
    logic [ArithW-1:0] b;
  } arith_req_t;

  typedef struct packed {
    logic              done;
    logic [ArithW-1:0] res;
  } arith_rsp_t;

endpackage

### hw/rtl/point_charge_field_accumulator.sv
// Work per charge: a charge with nonzero q off the test point runs through the shared
// iterative unit (one multiplier bit, one quotient bit or one root digit a cycle): three
// squarings, a 64-step root, s*d, then per axis a multiply and a 128-step divide. Skipped
// charges go from idle through the check state only; a final charge adds the magnitude pass.
// Throughput is one charge at a time in the back end; a short queue buffers the front.
// Reset clears test point, accumulators, singular flag and queue; no clearing pass.
module point_charge_field_accumulator #(
  parameter int unsigned QueueDepth = pcfa_pkg::QueueDepth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pcfa_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [31:0]             charge_nanocoulomb_i,
  input  logic signed [31:0]             source_x_i,
  input  logic signed [31:0]             source_y_i,
  input  logic signed [31:0]             source_z_i,
  input  logic                           final_charge_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [47:0]                    field_magnitude_o,
  output logic signed [15:0]             direction_x_o,
  output logic signed [15:0]             direction_y_o,
  output logic signed [15:0]             direction_z_o,
  output logic                           singular_seen_o,
  output logic                           zero_field_o
);

  pcfa_pkg::item_t   push_item, pop_item;
  pcfa_pkg::result_t res;
  logic              push, pop, full, fifo_valid;

  pcfa_front u_front (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .charge_nanocoulomb_i (charge_nanocoulomb_i),
    .source_x_i           (source_x_i),
    .source_y_i           (source_y_i),
    .source_z_i           (source_z_i),
    .final_charge_i       (final_charge_i),
    .full_i               (full),
    .push_o               (push),
    .item_o               (push_item)
  );

  pcfa_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .item_o  (pop_item)
  );

  pcfa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_valid_i (fifo_valid),
    .fifo_item_i  (pop_item),
    .fifo_pop_o   (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_o        (res)
  );

  assign field_magnitude_o = res.mag;
  assign direction_x_o     = res.dir[0];
  assign direction_y_o     = res.dir[1];
  assign direction_z_o     = res.dir[2];
  assign singular_seen_o   = res.singular;
  assign zero_field_o      = res.zero;

endmodule

### hw/rtl/pcfa_front.sv
// Front end: test point registers, input transfer and classification of charges.
// Depends on pcfa_pkg.
module pcfa_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pcfa_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  logic [31:0]                      cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [31:0]               charge_nanocoulomb_i,
  input  logic signed [31:0]               source_x_i,
  input  logic signed [31:0]               source_y_i,
  input  logic signed [31:0]               source_z_i,
  input  logic                             final_charge_i,
  input  logic                             full_i,
  output logic                             push_o,
  output pcfa_pkg::item_t                  item_o
);

  logic [31:0] tp_q [3];
  logic [31:0] src [3];
  logic [31:0] abs_q;
  logic [2:0][32:0] r;
  logic        on_point;
  logic        q_zero;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tp_q[0] <= '0;
      tp_q[1] <= '0;
      tp_q[2] <= '0;
    end else if (cfg_valid_i) begin
      unique case (pcfa_pkg::cfg_idx_e'(cfg_index_i))
        pcfa_pkg::CfgTpX: tp_q[0] <= cfg_data_i;
        pcfa_pkg::CfgTpY: tp_q[1] <= cfg_data_i;
        pcfa_pkg::CfgTpZ: tp_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign src[0] = source_x_i;
  assign src[1] = source_y_i;
  assign src[2] = source_z_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r[i] = {tp_q[i][31], tp_q[i]} - {src[i][31], src[i]};
    end
  end

  assign abs_q    = charge_nanocoulomb_i[31] ? 32'd0 - charge_nanocoulomb_i
                                             : charge_nanocoulomb_i;
  assign on_point = (r[0] == '0) && (r[1] == '0) && (r[2] == '0);
  assign q_zero   = (charge_nanocoulomb_i == '0);

  always_comb begin
    item_o.r        = r;
    item_o.kq       = {abs_q, 3'b000} + {3'b000, abs_q};
    item_o.qneg     = charge_nanocoulomb_i[31];
    item_o.singular = on_point;
    item_o.skip     = on_point || q_zero;
    item_o.last     = final_charge_i;
  end

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

### hw/rtl/pcfa_fifo.sv
// Short queue of classified charges between front and back end.
// Depends on pcfa_pkg.
module pcfa_fifo #(
  parameter int unsigned Depth = pcfa_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pcfa_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output pcfa_pkg::item_t item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  pcfa_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

### hw/rtl/pcfa_arith.sv
// Shared iterative unit: shift-add multiply, restoring divide, digit-by-digit root.
// One bit or one root digit per cycle. Depends on pcfa_pkg.
module pcfa_arith (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pcfa_pkg::arith_req_t req_i,
  output pcfa_pkg::arith_rsp_t rsp_o
);

  localparam int unsigned W    = pcfa_pkg::ArithW;
  localparam int unsigned CntW = $clog2(W);

  logic                busy_q, busy_d, done_q, done_d;
  pcfa_pkg::arith_op_e op_q, op_d;
  logic [W-1:0]        acc_q, acc_d, x_q, x_d, y_q, y_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [W:0]          rem_sh;
  logic [W-1:0]        root_try;

  assign rem_sh   = {acc_q, x_q[W-1]};
  assign root_try = x_q + y_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    acc_d  = acc_q;
    x_d    = x_q;
    y_d    = y_q;
    cnt_d  = cnt_q;
    if (!busy_q) begin
      if (req_i.start) begin
        busy_d = 1'b1;
        op_d   = req_i.op;
        cnt_d  = '1;
        unique case (req_i.op)
          pcfa_pkg::OpSqrt: begin
            acc_d = req_i.a;
            x_d   = '0;
            y_d   = {2'b01, {(W-2){1'b0}}};
          end
          default: begin
            acc_d = '0;
            x_d   = req_i.a;
            y_d   = req_i.b;
          end
        endcase
      end
    end else begin
      unique case (op_q)
        pcfa_pkg::OpMul: begin
          if (y_q == '0) begin
            busy_d = 1'b0;
            done_d = 1'b1;
          end else begin
            if (y_q[0]) begin
              acc_d = acc_q + x_q;
            end
            x_d = x_q << 1;
            y_d = y_q >> 1;
          end
        end
        pcfa_pkg::OpDiv: begin
          if (rem_sh >= {1'b0, y_q}) begin
            acc_d = W'(rem_sh - {1'b0, y_q});
            x_d   = {x_q[W-2:0], 1'b1};
          end else begin
            acc_d = rem_sh[W-1:0];
            x_d   = {x_q[W-2:0], 1'b0};
          end
          cnt_d = cnt_q - 1'b1;
          if (cnt_q == '0) begin
            busy_d = 1'b0;
            done_d = 1'b1;
          end
        end
        pcfa_pkg::OpSqrt: begin
          if (acc_q >= root_try) begin
            acc_d = acc_q - root_try;
            x_d   = (x_q >> 1) + y_q;
          end else begin
            x_d   = x_q >> 1;
          end
          y_d = y_q >> 2;
          if (y_q[W-1:2] == '0) begin
            busy_d = 1'b0;
            done_d = 1'b1;
          end
        end
        default: busy_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= pcfa_pkg::OpMul;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
    cnt_q <= cnt_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = (op_q == pcfa_pkg::OpMul) ? acc_q : x_q;

endmodule

### hw/rtl/pcfa_back.sv
// Back end: sequencer that works each charge through the shared arithmetic unit,
// keeps the field accumulators and holds the result. Depends on pcfa_pkg, pcfa_arith.
module pcfa_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fifo_valid_i,
  input  pcfa_pkg::item_t   fifo_item_i,
  output logic              fifo_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pcfa_pkg::result_t out_o
);

  localparam int unsigned W = pcfa_pkg::ArithW;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_SQ     = 11'b000_0000_0010,
    S_SQRT_S = 11'b000_0000_0100,
    S_DEN    = 11'b000_0000_1000,
    S_NUM    = 11'b000_0001_0000,
    S_DIV    = 11'b000_0010_0000,
    S_CHK    = 11'b000_0100_0000,
    S_E2     = 11'b000_1000_0000,
    S_SQRT_E = 11'b001_0000_0000,
    S_DIR    = 11'b010_0000_0000,
    S_OUT    = 11'b100_0000_0000
  } back_state_e;

  back_state_e          state_q, state_d;
  logic                 wait_q, wait_d;
  logic [1:0]           ax_q, ax_d;
  pcfa_pkg::item_t      item_q, item_d;
  logic [65:0]          s_q, s_d;
  logic [33:0]          d_q, d_d;
  logic [98:0]          den_q, den_d;
  logic [66:0]          num_q, num_d;
  logic [63:0]          acc_q [3];
  logic [63:0]          acc_d [3];
  logic                 sing_q, sing_d;
  logic [127:0]         e2_q, e2_d;
  logic [63:0]          m_q, m_d;
  logic [2:0][15:0]     dir_q, dir_d;
  pcfa_pkg::result_t    out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  pcfa_pkg::arith_req_t req;
  pcfa_pkg::arith_rsp_t rsp;
  logic [32:0]          r_cur, abs_r;
  logic [63:0]          acc_cur, abs_acc;
  logic                 computing;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] sum;
    sum = {a[63], a} + {b[63], b};
    if (sum[64] != sum[63]) begin
      return sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return sum[63:0];
  endfunction

  // Signed contribution from an unsigned quotient, clamped to 64 bits.
  function automatic logic [63:0] contrib(input logic [W-1:0] quo, input logic neg);
    logic big;
    big = (quo[W-1:63] != '0);
    if (quo == '0) begin
      return '0;
    end
    if (neg) begin
      return big ? {1'b1, 63'd0} : 64'd0 - quo[63:0];
    end
    return big ? {1'b0, {63{1'b1}}} : quo[63:0];
  endfunction

  // Negative directions wrap, positive ones clamp at full scale.
  function automatic logic [15:0] dir_fn(input logic neg, input logic [63:0] quo);
    logic [63:0] nq;
    nq = 64'd0 - quo;
    if (neg) begin
      return nq[15:0];
    end
    return (quo[63:15] != '0) ? 16'h7fff : quo[15:0];
  endfunction

  assign r_cur   = item_q.r[ax_q];
  assign abs_r   = r_cur[32] ? 33'd0 - r_cur : r_cur;
  assign acc_cur = acc_q[ax_q];
  assign abs_acc = acc_cur[63] ? 64'd0 - acc_cur : acc_cur;

  assign computing = (state_q == S_SQ) || (state_q == S_SQRT_S) || (state_q == S_DEN)
                  || (state_q == S_NUM) || (state_q == S_DIV) || (state_q == S_E2)
                  || (state_q == S_SQRT_E) || (state_q == S_DIR);

  always_comb begin
    req.start = computing && !wait_q;
    req.op    = pcfa_pkg::OpMul;
    req.a     = '0;
    req.b     = '0;
    unique case (state_q)
      S_SQ: begin
        req.a = W'(abs_r);
        req.b = W'(abs_r);
      end
      S_SQRT_S: begin
        req.op = pcfa_pkg::OpSqrt;
        req.a  = W'(s_q);
      end
      S_DEN: begin
        req.a = W'(s_q);
        req.b = W'(d_q);
      end
      S_NUM: begin
        req.a = W'(item_q.kq);
        req.b = W'(abs_r);
      end
      S_DIV: begin
        req.op = pcfa_pkg::OpDiv;
        req.a  = W'({num_q, 48'd0});
        req.b  = W'(den_q);
      end
      S_E2: begin
        req.a = W'(abs_acc);
        req.b = W'(abs_acc);
      end
      S_SQRT_E: begin
        req.op = pcfa_pkg::OpSqrt;
        req.a  = e2_q;
      end
      S_DIR: begin
        req.op = pcfa_pkg::OpDiv;
        req.a  = W'({abs_acc, 15'd0});
        req.b  = W'(m_q);
      end
      default: ;
    endcase
  end

  pcfa_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always_comb begin
    state_d     = state_q;
    ax_d        = ax_q;
    item_d      = item_q;
    s_d         = s_q;
    d_d         = d_q;
    den_d       = den_q;
    num_d       = num_q;
    acc_d       = acc_q;
    sing_d      = sing_q;
    e2_d        = e2_q;
    m_d         = m_q;
    dir_d       = dir_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    fifo_pop_o  = 1'b0;
    wait_d      = wait_q;
    if (req.start) begin
      wait_d = 1'b1;
    end
    if (rsp.done) begin
      wait_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (fifo_valid_i) begin
          fifo_pop_o = 1'b1;
          item_d     = fifo_item_i;
          ax_d       = '0;
          s_d        = '0;
          if (fifo_item_i.singular) begin
            sing_d = 1'b1;
          end
          state_d = fifo_item_i.skip ? S_CHK : S_SQ;
        end
      end
      S_SQ: begin
        if (rsp.done) begin
          s_d = s_q + rsp.res[65:0];
          if (ax_q == 2'd2) begin
            ax_d    = '0;
            state_d = S_SQRT_S;
          end else begin
            ax_d = ax_q + 1'b1;
          end
        end
      end
      S_SQRT_S: begin
        if (rsp.done) begin
          d_d     = rsp.res[33:0];
          state_d = S_DEN;
        end
      end
      S_DEN: begin
        if (rsp.done) begin
          den_d   = rsp.res[98:0];
          state_d = S_NUM;
        end
      end
      S_NUM: begin
        if (rsp.done) begin
          num_d   = rsp.res[66:0];
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (rsp.done) begin
          acc_d[ax_q] = sat_add(acc_cur, contrib(rsp.res, item_q.qneg ^ r_cur[32]));
          if (ax_q == 2'd2) begin
            ax_d    = '0;
            state_d = S_CHK;
          end else begin
            ax_d    = ax_q + 1'b1;
            state_d = S_NUM;
          end
        end
      end
      S_CHK: begin
        if (item_q.last) begin
          ax_d    = '0;
          e2_d    = '0;
          state_d = S_E2;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_E2: begin
        if (rsp.done) begin
          e2_d = e2_q + rsp.res;
          if (ax_q == 2'd2) begin
            ax_d    = '0;
            state_d = S_SQRT_E;
          end else begin
            ax_d = ax_q + 1'b1;
          end
        end
      end
      S_SQRT_E: begin
        if (rsp.done) begin
          m_d   = rsp.res[63:0];
          dir_d = '0;
          ax_d  = '0;
          state_d = (rsp.res[63:0] == '0) ? S_OUT : S_DIR;
        end
      end
      S_DIR: begin
        if (rsp.done) begin
          dir_d[ax_q] = dir_fn(acc_cur[63], rsp.res[63:0]);
          if (ax_q == 2'd2) begin
            state_d = S_OUT;
          end else begin
            ax_d = ax_q + 1'b1;
          end
        end
      end
      S_OUT: begin
        // Hold until the previous result has been taken.
        if (!out_valid_q || out_ready_i) begin
          out_d.mag      = (m_q[63:48] != '0) ? '1 : m_q[47:0];
          out_d.dir      = dir_q;
          out_d.singular = sing_q;
          out_d.zero     = (m_q == '0);
          out_valid_d    = 1'b1;
          acc_d[0]       = '0;
          acc_d[1]       = '0;
          acc_d[2]       = '0;
          sing_d         = 1'b0;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wait_q      <= 1'b0;
      ax_q        <= '0;
      acc_q[0]    <= '0;
      acc_q[1]    <= '0;
      acc_q[2]    <= '0;
      sing_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wait_q      <= wait_d;
      ax_q        <= ax_d;
      acc_q       <= acc_d;
      sing_q      <= sing_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    s_q    <= s_d;
    d_q    <= d_d;
    den_q  <= den_d;
    num_q  <= num_d;
    e2_q   <= e2_d;
    m_q    <= m_d;
    dir_q  <= dir_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

### hw/rtl/pcfa_checker.sv
// Port-level checks of the point charge field accumulator, bound to the top level.
// Depends on pcfa_pkg and point_charge_field_accumulator_macros.svh.
`include "point_charge_field_accumulator_macros.svh"

module pcfa_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_o,
  input logic [pcfa_pkg::CfgIndexW-1:0] cfg_index_i,
  input logic [31:0]                    cfg_data_i,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic signed [31:0]             charge_nanocoulomb_i,
  input logic signed [31:0]             source_x_i,
  input logic signed [31:0]             source_y_i,
  input logic signed [31:0]             source_z_i,
  input logic                           final_charge_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [47:0]                    field_magnitude_o,
  input logic signed [15:0]             direction_x_o,
  input logic signed [15:0]             direction_y_o,
  input logic signed [15:0]             direction_z_o,
  input logic                           singular_seen_o,
  input logic                           zero_field_o
);

  `PCFA_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(field_magnitude_o) && $stable(zero_field_o), "result dropped")

  `PCFA_ASSERT_IMP(a_zero_dir, out_valid_o && zero_field_o,
    direction_x_o == '0 && direction_y_o == '0 && direction_z_o == '0 &&
    field_magnitude_o == '0, "zero field with nonzero output")

  `PCFA_ASSERT_IMP(a_mag_nonzero, out_valid_o && !zero_field_o,
    field_magnitude_o != '0, "nonzero field with zero magnitude")

endmodule

bind point_charge_field_accumulator pcfa_checker u_pcfa_checker (.*);

### test/point_charge_field_accumulator_tb.sv
// Testbench for the point charge field accumulator: directed and random charge sets
// checked against a bit-exact field predictor. Depends on pcfa_pkg and the block only.
`timescale 1ns / 1ps

module point_charge_field_accumulator_tb;

  localparam logic [pcfa_pkg::CfgIndexW-1:0] CfgUnusedIdx = 2'd3;
  localparam int unsigned          StallLimit   = 20000;
  localparam int unsigned          SettleCycles = 1300;

  typedef struct {
    logic [47:0]        mag;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic               singular;
    logic               zero;
  } field_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [pcfa_pkg::CfgIndexW-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [31:0] charge_nanocoulomb_i = '0;
  logic signed [31:0] source_x_i = '0;
  logic signed [31:0] source_y_i = '0;
  logic signed [31:0] source_z_i = '0;
  logic final_charge_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [47:0] field_magnitude_o;
  logic signed [15:0] direction_x_o;
  logic signed [15:0] direction_y_o;
  logic signed [15:0] direction_z_o;
  logic singular_seen_o;
  logic zero_field_o;

  // predictor state
  logic signed [31:0] point_x, point_y, point_z;
  longint field_x, field_y, field_z;
  bit singular_pending;
  field_result_t expected_fields[$];

  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  point_charge_field_accumulator i_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= (recv_stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [63:0] magnitude_of(longint v);
    logic [63:0] u;
    u = v;
    return v < 0 ? ~u + 64'd1 : u;
  endfunction

  function automatic logic [63:0] floor_root(logic [127:0] n);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (n >= {64'd0, trial} * {64'd0, trial}) root = trial;
    end
    return root;
  endfunction

  function automatic longint axis_share(logic [63:0] kq, bit qneg, longint r,
                                        logic [127:0] den);
    logic [127:0] quo;
    bit neg;
    bit big;
    quo = (({64'd0, kq} * {64'd0, magnitude_of(r)}) << 48) / den;
    neg = qneg != (r < 0);
    big = quo > 128'h7FFF_FFFF_FFFF_FFFF;
    if (quo == 0) return 0;
    if (neg) return big ? 64'sh8000_0000_0000_0000 : -longint'(quo[63:0]);
    return big ? 64'sh7FFF_FFFF_FFFF_FFFF : longint'(quo[63:0]);
  endfunction

  function automatic longint add_clamped(longint a, longint b);
    logic signed [64:0] sum;
    sum = 65'(a) + 65'(b);
    if (sum > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (sum < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return sum[63:0];
  endfunction

  function automatic logic [15:0] unit_component(longint e, logic [63:0] m);
    logic [127:0] quo;
    logic [63:0] q;
    quo = ({64'd0, magnitude_of(e)} << 15) / {64'd0, m};
    q = quo[63:0];
    if (e < 0) return 16'(64'd0 - q);
    return q > 64'd32767 ? 16'd32767 : q[15:0];
  endfunction

  // Fold one charge into the running field; push the result on a final charge.
  task automatic predict_field(logic signed [31:0] q, logic signed [31:0] sx,
                               logic signed [31:0] sy, logic signed [31:0] sz, bit last);
    longint rx, ry, rz;
    logic [127:0] s, den, e2;
    logic [63:0] d, kq, m;
    field_result_t res;
    rx = longint'(point_x) - longint'(sx);
    ry = longint'(point_y) - longint'(sy);
    rz = longint'(point_z) - longint'(sz);
    s = {64'd0, magnitude_of(rx)} * magnitude_of(rx) + {64'd0, magnitude_of(ry)} *
        magnitude_of(ry) + {64'd0, magnitude_of(rz)} * magnitude_of(rz);
    if (s == 0) begin
      singular_pending = 1'b1;
    end else if (q != 0) begin
      d = floor_root(s);
      den = s * {64'd0, d};
      kq = 64'd9 * magnitude_of(longint'(q));
      field_x = add_clamped(field_x, axis_share(kq, q < 0, rx, den));
      field_y = add_clamped(field_y, axis_share(kq, q < 0, ry, den));
      field_z = add_clamped(field_z, axis_share(kq, q < 0, rz, den));
    end
    if (!last) return;
    // the sum of squares always fits in 128 bits
    e2 = {64'd0, magnitude_of(field_x)} * magnitude_of(field_x) +
         {64'd0, magnitude_of(field_y)} * magnitude_of(field_y) +
         {64'd0, magnitude_of(field_z)} * magnitude_of(field_z);
    m = floor_root(e2);
    res.mag = m > 64'hFFFF_FFFF_FFFF ? 48'hFFFF_FFFF_FFFF : m[47:0];
    res.zero = m == 0;
    res.dir_x = (m == 0) ? 16'sd0 : unit_component(field_x, m);
    res.dir_y = (m == 0) ? 16'sd0 : unit_component(field_y, m);
    res.dir_z = (m == 0) ? 16'sd0 : unit_component(field_z, m);
    res.singular = singular_pending;
    expected_fields.push_back(res);
    field_x = 0;
    field_y = 0;
    field_z = 0;
    singular_pending = 1'b0;
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Output transfers complete at the next rising edge; check them at the falling edge before it.
  always @(negedge clk_i) begin
    field_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_fields.size() == 0) begin
        report_mismatch("unexpected result", field_magnitude_o, 0);
      end else begin
        want = expected_fields.pop_front();
        if (field_magnitude_o !== want.mag)
          report_mismatch("field_magnitude", field_magnitude_o, want.mag);
        if (direction_x_o !== want.dir_x) report_mismatch("direction_x", direction_x_o, want.dir_x);
        if (direction_y_o !== want.dir_y) report_mismatch("direction_y", direction_y_o, want.dir_y);
        if (direction_z_o !== want.dir_z) report_mismatch("direction_z", direction_z_o, want.dir_z);
        if (singular_seen_o !== want.singular)
          report_mismatch("singular_seen", singular_seen_o, want.singular);
        if (zero_field_o !== want.zero) report_mismatch("zero_field", zero_field_o, want.zero);
      end
    end
  end

  always @(negedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Called just after a rising edge; returns just after the transfer edge.
  task automatic send_charge(logic signed [31:0] q, logic signed [31:0] sx,
                             logic signed [31:0] sy, logic signed [31:0] sz, bit last);
    bit done;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    charge_nanocoulomb_i <= q;
    source_x_i <= sx;
    source_y_i <= sy;
    source_z_i <= sz;
    final_charge_i <= last;
    done = 1'b0;
    while (!done) begin
      @(negedge clk_i);
      done = in_ready_o;
      @(posedge clk_i);
    end
    predict_field(q, sx, sy, sz, last);
  endtask

  // Hold until every result is back and any trailing charge has left the pipeline.
  task automatic settle;
    in_valid_i <= 1'b0;
    while (expected_fields.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_test_point(logic [pcfa_pkg::CfgIndexW-1:0] idx, logic [31:0] value);
    bit done;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    done = 1'b0;
    while (!done) begin
      @(negedge clk_i);
      done = cfg_ready_o;
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      pcfa_pkg::CfgTpX: point_x = value;
      pcfa_pkg::CfgTpY: point_y = value;
      pcfa_pkg::CfgTpZ: point_z = value;
      default: ;
    endcase
  endtask

  task automatic set_test_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    settle();
    write_test_point(pcfa_pkg::CfgTpX, x);
    write_test_point(pcfa_pkg::CfgTpY, y);
    write_test_point(pcfa_pkg::CfgTpZ, z);
  endtask

  task automatic test_directed;
    // single-axis fields, charge on the test point, zero field, extremes
    send_charge(32'sd1, -32'sd65536, 32'sd0, 32'sd0, 1'b1);
    send_charge(-32'sd5, 32'sd0, 32'sd131072, 32'sd0, 1'b1);
    send_charge(32'sd7, 32'sd0, 32'sd0, 32'sd65536, 1'b1);
    send_charge(32'sd100, 32'sd0, 32'sd0, 32'sd0, 1'b1);
    send_charge(32'sd0, 32'sd65536, 32'sd65536, 32'sd65536, 1'b1);
    send_charge(32'sh7FFF_FFFF, 32'sd1, 32'sd0, 32'sd0, 1'b1);
    send_charge(32'sh8000_0000, 32'sd0, -32'sd1, 32'sd1, 1'b1);
    send_charge(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
    send_charge(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1);
    // opposing charges cancel; singular mixed into a running sum
    send_charge(32'sd50, 32'sd65536, 32'sd0, 32'sd0, 1'b0);
    send_charge(32'sd50, -32'sd65536, 32'sd0, 32'sd0, 1'b0);
    send_charge(32'sd3, 32'sd0, 32'sd0, 32'sd0, 1'b1);
    send_charge(32'sh7FFF_FFFF, 32'sd1, 32'sd1, 32'sd1, 1'b0);
    send_charge(32'sh7FFF_FFFF, 32'sd1, 32'sd1, 32'sd1, 1'b0);
    send_charge(32'sh7FFF_FFFF, 32'sd1, 32'sd1, 32'sd2, 1'b1);
  endtask

  task automatic test_point_extremes;
    set_test_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    write_test_point(CfgUnusedIdx, 32'h1234_5678);
    send_charge(32'sd9, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
    send_charge(-32'sd9, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
    send_charge(32'sd1, 32'sh7FFF_FFFE, 32'sh8000_0001, 32'sh7FFF_FFFF, 1'b1);
    set_test_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_charge(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
    send_charge(32'sd2, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
  endtask

  function automatic logic [31:0] random_charge();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2000)) - 1000);
      2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(200000)) - 100000);
    endcase
  endfunction

  function automatic logic [31:0] random_coord(logic [31:0] centre);
    case ($urandom_range(9))
      0: return $urandom;
      1: return centre;
      2: return centre + 32'($signed($urandom_range(16)) - 8);
      default: return centre + 32'($signed($urandom_range(1 << 20)) - (1 << 19));
    endcase
  endfunction

  task automatic test_random(int unsigned count);
    int unsigned sent;
    int unsigned group;
    sent = 0;
    while (sent < count) begin
      group = $urandom_range(1, 6);
      for (int unsigned i = 0; i < group; i++) begin
        if ($urandom_range(19) == 0) begin
          send_charge(random_charge(), point_x, point_y, point_z, i == group - 1);
        end else begin
          send_charge(random_charge(), random_coord(point_x), random_coord(point_y),
                      random_coord(point_z), i == group - 1);
        end
      end
      sent += group;
    end
  endtask

  initial begin
    point_x = '0;
    point_y = '0;
    point_z = '0;
    field_x = 0;
    field_y = 0;
    field_z = 0;
    singular_pending = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_point_extremes();

    set_test_point(32'h0, 32'h0, 32'h0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(200);

    set_test_point($urandom, $urandom, $urandom);
    send_idle_pct = 49;
    test_random(200);

    set_test_point(32'($signed($urandom_range(1 << 22)) - (1 << 21)), 32'h0001_0000,
                   32'hFFFF_0000);
    send_idle_pct = 0;
    recv_stall_pct = 49;
    test_random(200);

    set_test_point($urandom, 32'h7FFF_FFFF, 32'h8000_0000);
    send_idle_pct = 36;
    recv_stall_pct = 36;
    test_random(200);

    settle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
